// ----- hdl/mss_pkg.sv -----
// ============================================================================
// mss_pkg - shared types and constants for the step pulse scheduler
// Motor count, per-motor record layouts and the service result bundle.
// ============================================================================
package mss_pkg;

    localparam int MOTOR_COUNT = 4;
    localparam int IDX_W       = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
    localparam int STEP_W      = 32;
    localparam int IVL_W       = 32;
    localparam int PULSE_W     = 4;
    localparam int MIDX_W      = 2;

    typedef logic [IDX_W-1:0] t_idx;

    localparam t_idx LAST_IDX = t_idx'(MOTOR_COUNT - 1);

    // Running state of one motor.
    typedef struct packed {
        logic [STEP_W-1:0] remaining;
        logic [IVL_W-1:0]  countdown;
        logic [IVL_W-1:0]  interval;
        logic              drive;
    } t_act;

    // Staged command entry of one motor.
    typedef struct packed {
        logic [STEP_W-1:0] steps;
        logic [IVL_W-1:0]  interval;
        logic              drive;
    } t_stg;

    // What the service unit hands back for one motor.
    typedef struct packed {
        t_act next;
        logic step;
        logic busy;
    } t_svc;

endpackage

// ----- hdl/mss_cmd_if.sv -----
// ============================================================================
// mss_cmd_if - input channel of the step pulse scheduler
// Valid/ready channel carrying one tick or one command entry per transfer.
// ============================================================================
interface mss_cmd_if import mss_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              cmd;
    logic [MIDX_W-1:0] motor_index;
    logic [STEP_W-1:0] step_total;
    logic [IVL_W-1:0]  interval_ticks;
    logic              drive_enable;
    logic              last_entry;

    modport source (
        output valid, cmd, motor_index, step_total, interval_ticks, drive_enable,
               last_entry,
        input  ready
    );
    modport sink (
        input  valid, cmd, motor_index, step_total, interval_ticks, drive_enable,
               last_entry,
        output ready
    );
endinterface

// ----- hdl/mss_res_if.sv -----
// ============================================================================
// mss_res_if - result channel of the step pulse scheduler
// Valid/ready channel carrying one status word per transfer.
// ============================================================================
interface mss_res_if import mss_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [PULSE_W-1:0] step_pulses;
    logic               motors_enabled;
    logic               command_started;
    logic               busy_res;
    logic               staging_free;
    logic               write_accepted;

    modport source (
        output valid, step_pulses, motors_enabled, command_started, busy_res,
               staging_free, write_accepted,
        input  ready
    );
    modport sink (
        input  valid, step_pulses, motors_enabled, command_started, busy_res,
               staging_free, write_accepted,
        output ready
    );
endinterface

// ----- hdl/mss_ram.sv -----
// ============================================================================
// mss_ram - simple dual-port synchronous RAM
// One write port and one read port, read data registered.
// ============================================================================
module mss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/mss_service.sv -----
// ============================================================================
// mss_service - per-motor service step
// Optionally loads a staged entry, then advances one motor by one tick.
// ============================================================================
module mss_service import mss_pkg::*; (
    input  logic i_load,
    input  t_act i_act,
    input  t_stg i_stg,
    output t_svc o_svc
);

    t_act base;
    t_act nxt;
    logic step;

    always_comb begin
        if (i_load) begin
            base.remaining = i_stg.steps;
            base.countdown = i_stg.interval;
            base.interval  = i_stg.interval;
            base.drive     = i_stg.drive;
        end else begin
            base = i_act;
        end

        nxt  = base;
        step = 1'b0;
        // A motor with steps left either fires and reloads, or counts down.
        if (base.remaining != '0) begin
            if (base.countdown == '0) begin
                nxt.countdown = base.interval;
                nxt.remaining = base.remaining - STEP_W'(1);
                step          = base.drive;
            end else begin
                nxt.countdown = base.countdown - IVL_W'(1);
            end
        end
    end

    assign o_svc.next = nxt;
    assign o_svc.step = step;
    assign o_svc.busy = (nxt.remaining != '0);

endmodule

// ----- hdl/multi_axis_step_pulse_scheduler.sv -----
// ============================================================================
// multi_axis_step_pulse_scheduler - staged multi-motor step pulse scheduler
// A command-entry write goes from IDLE straight to FIN; a tick walks READ and
// WRITE once per motor before FIN. Items are taken one at a time; a tick is a
// read-modify-write walk over the motor state RAM, one motor after another.
// Reset: synchronous active-low; clears control state and the per-entry valid
// bits, so every motor and staging entry reads as zero with no clearing pass.
// ============================================================================
module multi_axis_step_pulse_scheduler import mss_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mss_cmd_if.sink   i_cmd,
    mss_res_if.source o_res
);

    // Sequencer states. A tick walks READ/WRITE once per motor; every item
    // ends in FIN, which hands its result to the output register.
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_READ  = 2'd1;
    localparam logic [1:0] S_WRITE = 2'd2;
    localparam logic [1:0] S_FIN   = 2'd3;

    localparam int ACT_W = $bits(t_act);
    localparam int STG_W = $bits(t_stg);

    logic [1:0]             r_state;
    t_idx                   r_idx;
    logic                   r_load;
    logic                   r_pending;
    logic                   r_enable;
    logic [MOTOR_COUNT-1:0] r_busy;
    logic [MOTOR_COUNT-1:0] r_act_vld;
    logic [MOTOR_COUNT-1:0] r_stg_vld;

    // Per-item result being built.
    logic [PULSE_W-1:0]     r_pulses;
    logic                   r_started;
    logic                   r_accepted;

    // Output register.
    logic                   r_ovalid;
    logic [PULSE_W-1:0]     r_o_pulses;
    logic                   r_o_enabled;
    logic                   r_o_started;
    logic                   r_o_busy;
    logic                   r_o_free;
    logic                   r_o_accepted;

    logic                   in_xfer;
    logic                   out_free;
    logic                   wr_ok;
    t_idx                   wr_idx;

    logic                   act_we;
    logic [ACT_W-1:0]       act_rdata;
    logic [STG_W-1:0]       stg_rdata;
    t_act                   act_cur;
    t_stg                   stg_cur;
    t_svc                   svc;

    assign i_cmd.ready = (r_state == S_IDLE);
    assign in_xfer     = i_cmd.valid && i_cmd.ready;
    assign out_free    = !r_ovalid || o_res.ready;

    // An entry is refused while a committed command waits, or when its motor
    // index lies beyond the motor count; a refused entry never commits.
    assign wr_idx = t_idx'(i_cmd.motor_index);
    assign wr_ok  = !r_pending && (32'(i_cmd.motor_index) < 32'(MOTOR_COUNT));

    // Running state of every motor lives in one RAM; the staged command in
    // another. Entries that were never written read as zero through the
    // valid bits, which is what reset leaves in the model.
    mss_ram #(.WIDTH(ACT_W), .DEPTH(MOTOR_COUNT)) u_act_ram (
        .i_clk   (i_clk),
        .i_we    (act_we),
        .i_waddr (r_idx),
        .i_wdata (svc.next),
        .i_raddr (r_idx),
        .o_rdata (act_rdata)
    );

    mss_ram #(.WIDTH(STG_W), .DEPTH(MOTOR_COUNT)) u_stg_ram (
        .i_clk   (i_clk),
        .i_we    (in_xfer && i_cmd.cmd && wr_ok),
        .i_waddr (wr_idx),
        .i_wdata ({i_cmd.step_total, i_cmd.interval_ticks, i_cmd.drive_enable}),
        .i_raddr (r_idx),
        .o_rdata (stg_rdata)
    );

    // The read in READ and the write-back in WRITE touch the same entry, and
    // the next read goes to the next entry, so no two accesses overlap.
    assign act_cur = r_act_vld[r_idx] ? t_act'(act_rdata) : '0;
    assign stg_cur = r_stg_vld[r_idx] ? t_stg'(stg_rdata) : '0;
    assign act_we  = (r_state == S_WRITE);

    mss_service u_service (
        .i_load (r_load),
        .i_act  (act_cur),
        .i_stg  (stg_cur),
        .o_svc  (svc)
    );

    // Control sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pending <= 1'b0;
            r_enable  <= 1'b0;
            r_busy    <= '0;
            r_act_vld <= '0;
            r_stg_vld <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        if (i_cmd.cmd) begin
                            if (wr_ok) begin
                                r_stg_vld[wr_idx] <= 1'b1;
                                if (i_cmd.last_entry) begin
                                    r_pending <= 1'b1;
                                end
                            end
                            r_state <= S_FIN;
                        end else begin
                            // A pending command loads only once all motors idle.
                            if (!(|r_busy) && r_pending) begin
                                r_pending <= 1'b0;
                                r_enable  <= 1'b1;
                            end
                            r_state <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    r_state <= S_WRITE;
                end
                S_WRITE: begin
                    r_act_vld[r_idx] <= 1'b1;
                    r_busy[r_idx]    <= svc.busy;
                    if (r_idx == LAST_IDX) begin
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_READ;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if (r_state == S_FIN && out_free) begin
                r_ovalid <= 1'b1;
            end else if (o_res.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Walk index, load flag and the result under construction.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && in_xfer) begin
            r_idx      <= '0;
            r_load     <= !i_cmd.cmd && !(|r_busy) && r_pending;
            r_started  <= !i_cmd.cmd && !(|r_busy) && r_pending;
            r_accepted <= i_cmd.cmd && wr_ok;
            r_pulses   <= '0;
        end else if (r_state == S_WRITE) begin
            // Motors past the width of the pulse field still step, unseen.
            r_pulses <= r_pulses | (PULSE_W'(svc.step) << r_idx);
            if (r_idx != LAST_IDX) begin
                r_idx <= r_idx + t_idx'(1);
            end
        end
    end

    // Output register; the status bits are sampled after the item finished.
    always_ff @(posedge i_clk) begin
        if (r_state == S_FIN && out_free) begin
            r_o_pulses   <= r_pulses;
            r_o_enabled  <= r_enable;
            r_o_started  <= r_started;
            r_o_busy     <= |r_busy;
            r_o_free     <= !r_pending;
            r_o_accepted <= r_accepted;
        end
    end

    assign o_res.valid           = r_ovalid;
    assign o_res.step_pulses     = r_o_pulses;
    assign o_res.motors_enabled  = r_o_enabled;
    assign o_res.command_started = r_o_started;
    assign o_res.busy_res        = r_o_busy;
    assign o_res.staging_free    = r_o_free;
    assign o_res.write_accepted  = r_o_accepted;

endmodule

// ----- hdl/mss_checker.sv -----
// ============================================================================
// mss_checker - port-level checks for the step pulse scheduler
// Watches both channels of the top level and is attached by bind.
// ============================================================================
module mss_checker import mss_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic [PULSE_W-1:0] i_step_pulses,
    input logic               i_motors_enabled,
    input logic               i_command_started,
    input logic               i_busy_res,
    input logic               i_staging_free,
    input logic               i_write_accepted
);

    logic [PULSE_W+4:0] payload;

    assign payload = {i_step_pulses, i_motors_enabled, i_command_started, i_busy_res,
                      i_staging_free, i_write_accepted};

    // A stalled result holds its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(payload))
        else $error("result changed while stalled");

    // Items are worked one at a time: no transfer directly after another.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken again right after a transfer");

    // Loading a command always latches the enable and leaves staging free.
    a_start_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_command_started |-> i_motors_enabled && i_staging_free)
        else $error("command start without enable or with staging full");

    // A stored entry comes from a write, which never steps or starts.
    a_write_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_write_accepted |-> i_step_pulses == '0 && !i_command_started)
        else $error("accepted write reports pulses or a start");

endmodule

bind multi_axis_step_pulse_scheduler mss_checker u_mss_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_cmd.valid),
    .i_in_ready        (i_cmd.ready),
    .i_out_valid       (o_res.valid),
    .i_out_ready       (o_res.ready),
    .i_step_pulses     (o_res.step_pulses),
    .i_motors_enabled  (o_res.motors_enabled),
    .i_command_started (o_res.command_started),
    .i_busy_res        (o_res.busy_res),
    .i_staging_free    (o_res.staging_free),
    .i_write_accepted  (o_res.write_accepted)
);

// ----- tb/tb.sv -----
// ============================================================================
// tb - self-checking bench for multi_axis_step_pulse_scheduler
// Drives ticks and command entries over the valid/ready input channel and
// checks each status word against a cycle-free model of the motor scheduler.
// A short directed table opens the run, then bounded command sequences run
// with random content, mixed with tick bursts and refused writes.
// ============================================================================
module tb;
    import mss_pkg::*;

    // The cmd bit of an input item selects between a tick and an entry write.
    typedef enum logic {
        OP_TICK  = 1'b0,
        OP_ENTRY = 1'b1
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [MIDX_W-1:0] idx;
        logic [STEP_W-1:0] steps;
        logic [IVL_W-1:0]  ivl;
        logic              drive;
        logic              last;
    } t_cmd_item;

    typedef struct packed {
        logic [PULSE_W-1:0] pulses;
        logic               enabled;
        logic               started;
        logic               busy;
        logic               free;
        logic               accepted;
    } t_status;

    // A row either carries a hand-written expectation or leaves it to the model.
    typedef struct packed {
        t_cmd_item it;
        logic      typed;
        t_status   want;
    } t_dir_row;

    localparam int             RAND_ITEMS  = 1950;
    localparam int             CYCLE_LIMIT = 500_000;
    localparam int             DRAIN_WAIT  = 2 * MOTOR_COUNT + 4;
    localparam int             DIR_ROWS    = 24;
    localparam int             MAX_REPORTS = 10;
    localparam logic [31:0]    ALL_ONES    = 32'hFFFF_FFFF;
    localparam t_status        UNTYPED     = '0;

    // Staging is built with a wide entry that is then overwritten, so the
    // first command runs three motors and the wide values never reach a motor.
    // Later rows cover a write refused while pending, an all-zero command,
    // staged entries that persist across commands, and a write while running.
    localparam t_dir_row DIR_TABLE [DIR_ROWS] = '{
        '{'{OP_TICK,  2'd0, 32'd0,    32'd0,    1'b0, 1'b0}, 1'b1,
          '{4'h0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0}},
        '{'{OP_ENTRY, 2'd0, ALL_ONES, ALL_ONES, 1'b1, 1'b0}, 1'b1,
          '{4'h0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1}},
        '{'{OP_ENTRY, 2'd0, 32'd3,    32'd0,    1'b1, 1'b0}, 1'b0, UNTYPED},
        '{'{OP_ENTRY, 2'd1, 32'd1,    32'd4,    1'b1, 1'b0}, 1'b0, UNTYPED},
        '{'{OP_ENTRY, 2'd2, 32'd2,    32'd1,    1'b0, 1'b0}, 1'b0, UNTYPED},
        '{'{OP_ENTRY, 2'd3, 32'd0,    32'd0,    1'b1, 1'b1}, 1'b1,
          '{4'h0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1}},
        '{'{OP_ENTRY, 2'd3, ALL_ONES, ALL_ONES, 1'b1, 1'b1}, 1'b1,
          '{4'h0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{'{OP_TICK,  2'd0, 32'd0,    32'd0,    1'b0, 1'b0}, 1'b0, UNTYPED},
        '{'{OP_TICK,  2'd3, ALL_ONES, ALL_ONES, 1'b1, 1'b1}, 1'b0, UNTYPED},
        '{'{OP_TICK,  2'd0, 32'd0,    32'd0,    1'b0, 1'b0}, 1'b0, UNTYPED},
        '{'{OP_TICK,  2'd0, 32'd0,    32'd0,    1'b0, 1'b0}, 1'b0, UNTYPED},
        '{'{OP_ENTRY, 2'd0, 32'd0,    32'd7,    1'b1, 1'b0}, 1'b0, UNTYPED},
        '{'{OP_ENTRY, 2'd1, 32'd0,    32'd0,    1'b0, 1'b0}, 1'b0, UNTYPED},
        '{'{OP_ENTRY, 2'd2, 32'd0,    32'd0,    1'b0, 1'b1}, 1'b0, UNTYPED},
        '{'{OP_TICK,  2'd0, 32'd0,    32'd0,    1'b0, 1'b0}, 1'b0, UNTYPED},
        '{'{OP_ENTRY, 2'd1, 32'd2,    32'd2,    1'b1, 1'b1}, 1'b0, UNTYPED},
        '{'{OP_TICK,  2'd0, 32'd0,    32'd0,    1'b0, 1'b0}, 1'b0, UNTYPED},
        '{'{OP_ENTRY, 2'd3, 32'd5,    32'd0,    1'b1, 1'b1}, 1'b0, UNTYPED},
        '{'{OP_TICK,  2'd0, 32'd0,    32'd0,    1'b0, 1'b0}, 1'b0, UNTYPED},
        '{'{OP_TICK,  2'd0, 32'd0,    32'd0,    1'b0, 1'b0}, 1'b0, UNTYPED},
        '{'{OP_TICK,  2'd0, 32'd0,    32'd0,    1'b0, 1'b0}, 1'b0, UNTYPED},
        '{'{OP_TICK,  2'd0, 32'd0,    32'd0,    1'b0, 1'b0}, 1'b0, UNTYPED},
        '{'{OP_TICK,  2'd0, 32'd0,    32'd0,    1'b0, 1'b0}, 1'b0, UNTYPED},
        '{'{OP_ENTRY, 2'd2, 32'd1,    32'd0,    1'b1, 1'b0}, 1'b0, UNTYPED}
    };

    logic i_clk;
    logic i_rst_n;

    mss_cmd_if cmd_ch ();
    mss_res_if res_ch ();

    multi_axis_step_pulse_scheduler dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_res   (res_ch)
    );

    // Model state: running motors, the staging slot and the two flags.
    logic [STEP_W-1:0] left_m   [MOTOR_COUNT] = '{default: '0};
    logic [IVL_W-1:0]  wait_m   [MOTOR_COUNT] = '{default: '0};
    logic [IVL_W-1:0]  ivl_m    [MOTOR_COUNT] = '{default: '0};
    logic              drv_m    [MOTOR_COUNT] = '{default: '0};
    logic [STEP_W-1:0] stg_steps[MOTOR_COUNT] = '{default: '0};
    logic [IVL_W-1:0]  stg_ivl  [MOTOR_COUNT] = '{default: '0};
    logic              stg_drv  [MOTOR_COUNT] = '{default: '0};
    logic              pend_m   = 1'b0;
    logic              en_m     = 1'b0;

    t_status status_due_q[$];
    int      fail_cnt     = 0;
    int      cycle_cnt    = 0;
    int      src_idle_pct = 38;
    int      snk_idle_pct = 76;
    int      rand_sent    = 0;

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    function automatic logic motors_busy();
        for (int m = 0; m < MOTOR_COUNT; m++) begin
            if (left_m[m] != '0) return 1'b1;
        end
        return 1'b0;
    endfunction

    // Applies one accepted item to the model and returns the status it causes.
    function automatic t_status next_status(input t_cmd_item it);
        t_status st;
        st = '0;
        if (it.op == OP_ENTRY) begin
            if (!pend_m && int'(it.idx) < MOTOR_COUNT) begin
                stg_steps[it.idx] = it.steps;
                stg_ivl[it.idx]   = it.ivl;
                stg_drv[it.idx]   = it.drive;
                if (it.last) pend_m = 1'b1;
                st.accepted = 1'b1;
            end
        end else begin
            // A pending command loads only once every motor has finished.
            if (!motors_busy() && pend_m) begin
                for (int m = 0; m < MOTOR_COUNT; m++) begin
                    left_m[m] = stg_steps[m];
                    wait_m[m] = stg_ivl[m];
                    ivl_m[m]  = stg_ivl[m];
                    drv_m[m]  = stg_drv[m];
                end
                pend_m     = 1'b0;
                en_m       = 1'b1;
                st.started = 1'b1;
            end
            for (int m = 0; m < MOTOR_COUNT; m++) begin
                if (left_m[m] != '0) begin
                    if (wait_m[m] == '0) begin
                        wait_m[m] = ivl_m[m];
                        left_m[m] = left_m[m] - 1'b1;
                        if (drv_m[m] && m < PULSE_W) st.pulses[m] = 1'b1;
                    end else begin
                        wait_m[m] = wait_m[m] - 1'b1;
                    end
                end
            end
        end
        st.enabled = en_m;
        st.busy    = motors_busy();
        st.free    = !pend_m;
        return st;
    endfunction

    function automatic t_cmd_item random_entry(input logic [MIDX_W-1:0] idx);
        t_cmd_item it;
        it.op    = OP_ENTRY;
        it.idx   = idx;
        it.steps = $urandom;
        it.ivl   = $urandom;
        it.drive = 1'($urandom_range(1));
        it.last  = 1'($urandom_range(1));
        return it;
    endfunction

    // Keeps every command finite: a long interval only with no steps, since
    // even a single step waits out the whole interval first.
    function automatic t_cmd_item bounded_entry(input logic [MIDX_W-1:0] idx,
                                                input logic last);
        t_cmd_item it;
        it       = random_entry(idx);
        it.last  = last;
        it.steps = ($urandom_range(4) == 0) ? $urandom_range(0, 8) : $urandom_range(0, 3);
        if (it.steps == 0 && $urandom_range(7) == 0) begin
            it.ivl = $urandom;
        end else begin
            it.ivl = ($urandom_range(4) == 0) ? $urandom_range(0, 10) : $urandom_range(0, 2);
        end
        return it;
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic drive_item(input t_cmd_item it, input logic typed, input t_status want);
        t_status st;
        while ($urandom_range(99) < src_idle_pct) begin
            cmd_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        cmd_ch.valid          <= 1'b1;
        cmd_ch.cmd            <= it.op;
        cmd_ch.motor_index    <= it.idx;
        cmd_ch.step_total     <= it.steps;
        cmd_ch.interval_ticks <= it.ivl;
        cmd_ch.drive_enable   <= it.drive;
        cmd_ch.last_entry     <= it.last;
        do @(posedge i_clk); while (!cmd_ch.ready);
        st = next_status(it);
        status_due_q.push_back(typed ? want : st);
        @(negedge i_clk);
    endtask

    task automatic tick_burst();
        t_cmd_item it;
        int        n;
        n = ($urandom_range(7) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 10);
        repeat (n) begin
            it    = random_entry(MIDX_W'($urandom_range(3)));
            it.op = OP_TICK;
            drive_item(it, 1'b0, UNTYPED);
            rand_sent++;
        end
    endtask

    task automatic note_failure(input string what, input t_status want, input t_status got);
        fail_cnt++;
        if (fail_cnt <= MAX_REPORTS) begin
            $display("%s: want pulses=%h en=%b start=%b busy=%b free=%b acc=%b",
                     what, want.pulses, want.enabled, want.started, want.busy,
                     want.free, want.accepted);
            $display("    got  pulses=%h en=%b start=%b busy=%b free=%b acc=%b",
                     got.pulses, got.enabled, got.started, got.busy, got.free,
                     got.accepted);
        end
    endtask

    // The receiver stalls at random according to the current phase.
    always @(negedge i_clk) begin
        res_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    always @(posedge i_clk) begin
        t_status got;
        t_status want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got = '{res_ch.step_pulses, res_ch.motors_enabled, res_ch.command_started,
                    res_ch.busy_res, res_ch.staging_free, res_ch.write_accepted};
            if (status_due_q.size() == 0) begin
                note_failure("unexpected status", UNTYPED, got);
            end else begin
                want = status_due_q.pop_front();
                if (got !== want) note_failure("status mismatch", want, got);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        t_cmd_item           it;
        int                  n;
        logic [MIDX_W-1:0]   idx;
        cmd_ch.valid          <= 1'b0;
        cmd_ch.cmd            <= OP_TICK;
        cmd_ch.motor_index    <= '0;
        cmd_ch.step_total     <= '0;
        cmd_ch.interval_ticks <= '0;
        cmd_ch.drive_enable   <= 1'b0;
        cmd_ch.last_entry     <= 1'b0;
        i_rst_n               <= 1'b0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (DIR_TABLE[r]) drive_item(DIR_TABLE[r].it, DIR_TABLE[r].typed, DIR_TABLE[r].want);

        while (rand_sent < RAND_ITEMS) begin
            // Three idling phases: receiver-heavy, sender-heavy, then none.
            if (rand_sent < RAND_ITEMS / 3) begin
                src_idle_pct = 38;
                snk_idle_pct = 76;
            end else if (rand_sent < 2 * RAND_ITEMS / 3) begin
                src_idle_pct = 76;
                snk_idle_pct = 38;
            end else begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end

            if (pend_m) begin
                // While a command waits, writes are refused, so any content goes.
                if ($urandom_range(9) < 2) begin
                    repeat ($urandom_range(1, 3)) begin
                        drive_item(random_entry(MIDX_W'($urandom_range(3))), 1'b0, UNTYPED);
                        rand_sent++;
                    end
                end else begin
                    tick_burst();
                end
            end else if ($urandom_range(9) < 6) begin
                // A staged command; a wide entry is always overwritten before the
                // commit, and now and then the commit is left out.
                n = $urandom_range(1, 5);
                for (int k = 0; k < n; k++) begin
                    idx = MIDX_W'($urandom_range(MOTOR_COUNT - 1));
                    if ($urandom_range(5) == 0) begin
                        it      = random_entry(idx);
                        it.last = 1'b0;
                        drive_item(it, 1'b0, UNTYPED);
                        rand_sent++;
                    end
                    it = bounded_entry(idx, (k == n - 1) && ($urandom_range(9) != 0));
                    drive_item(it, 1'b0, UNTYPED);
                    rand_sent++;
                end
            end else begin
                tick_burst();
            end
        end
        cmd_ch.valid <= 1'b0;

        while (status_due_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (fail_cnt == 0 && status_due_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/mss_pkg.sv
hdl/mss_cmd_if.sv
hdl/mss_res_if.sv
hdl/mss_ram.sv
hdl/mss_service.sv
hdl/multi_axis_step_pulse_scheduler.sv
hdl/mss_checker.sv
tb/tb.sv
